[src/lrab_pkg.sv]
// Shared types and constants for the layer rectangle alpha blender.
package lrab_pkg;

  localparam int unsigned NumChan = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgRectLeft = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRectTop = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRectRight = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRectBottom = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLayerColor = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgLayerOpacity = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgWipeEnable = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgWipeProgress = 3'd7;

  // Channel slots, red in the low byte
  localparam int unsigned ChanRed = 0;
  localparam int unsigned ChanGreen = 1;
  localparam int unsigned ChanBlue = 2;
  localparam int unsigned ChanAlpha = 3;

  // 255 * 255 full scale and its rounding offset
  localparam logic [15:0] FullScale = 16'd65025;
  localparam logic [23:0] HalfScale = 24'd32512;
  // floor(num / 65025) ~ (num * 16512) >> 30, never over, at most one under
  localparam logic [14:0] RecipMul = 15'd16512;
  localparam int unsigned RecipShift = 30;
  localparam int unsigned RecipW = 39;

  localparam logic [8:0] ProgressOne = 9'd256;

  typedef logic [7:0] byte_t;
  typedef logic [23:0] term_t;

  // Per-stage load enables for the blend lanes
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } lrab_en_t;

  // Layer terms fixed for the whole frame
  typedef struct packed {
    logic [15:0]               inv_cover;
    term_t [NumChan-1:0]       src_term;
  } lrab_blend_t;

endpackage

[src/lrab_cfg.sv]
// Configuration registers and the layer terms derived from them.
module lrab_cfg
  import lrab_pkg::*;
#(
  parameter int COORD_WIDTH = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [CfgDataW-1:0]    cfg_data_i,
  output logic [COORD_WIDTH:0]   left_o,
  output logic [COORD_WIDTH:0]   top_o,
  output logic [COORD_WIDTH:0]   bottom_o,
  output logic [COORD_WIDTH:0]   right_o,
  output lrab_blend_t            blend_o
);

  localparam int EdgeW = COORD_WIDTH + 1;
  localparam int ScaleW = EdgeW + 9;

  logic [EdgeW-1:0] left_q, top_q, right_q, bottom_q;
  logic [31:0]      color_q;
  logic [7:0]       opacity_q;
  logic             wipe_en_q;
  logic [8:0]       progress_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q     <= '0;
      top_q      <= '0;
      right_q    <= '0;
      bottom_q   <= '0;
      color_q    <= '0;
      opacity_q  <= 8'd255;
      wipe_en_q  <= 1'b0;
      progress_q <= ProgressOne;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgRectLeft:     left_q     <= cfg_data_i[EdgeW-1:0];
        CfgRectTop:      top_q      <= cfg_data_i[EdgeW-1:0];
        CfgRectRight:    right_q    <= cfg_data_i[EdgeW-1:0];
        CfgRectBottom:   bottom_q   <= cfg_data_i[EdgeW-1:0];
        CfgLayerColor:   color_q    <= cfg_data_i[31:0];
        CfgLayerOpacity: opacity_q  <= cfg_data_i[7:0];
        CfgWipeEnable:   wipe_en_q  <= cfg_data_i[0];
        CfgWipeProgress: progress_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // First derived stage: wiped width and coverage S * O
  logic [EdgeW-1:0]  wid_raw, wid_a_d, wid_a_q;
  logic [8:0]        prog_sat;
  logic [ScaleW-1:0] scaled;
  logic [15:0]       cover_a_d, cover_a_q;

  always_comb begin
    wid_raw   = (right_q > left_q) ? (right_q - left_q) : '0;
    prog_sat  = (progress_q > ProgressOne) ? ProgressOne : progress_q;
    scaled    = ScaleW'(wid_raw) * ScaleW'(prog_sat) + ScaleW'(128);
    wid_a_d   = wipe_en_q ? scaled[EdgeW+7:8] : wid_raw;
    cover_a_d = 16'(color_q[31:24]) * 16'(opacity_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wid_a_q   <= '0;
      cover_a_q <= '0;
    end else begin
      wid_a_q   <= wid_a_d;
      cover_a_q <= cover_a_d;
    end
  end

  // Second derived stage: right edge, 1 - a, premultiplied source terms
  logic [EdgeW-1:0] right_eff_q;
  lrab_blend_t      blend_d, blend_q;

  always_comb begin
    blend_d.inv_cover = FullScale - cover_a_q;
    for (int c = 0; c < NumChan; c++) begin
      if (c == ChanAlpha) begin
        blend_d.src_term[c] = 24'(8'd255) * 24'(cover_a_q) + HalfScale;
      end else begin
        blend_d.src_term[c] = 24'(color_q[8*c +: 8]) * 24'(cover_a_q) + HalfScale;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_eff_q        <= '0;
      blend_q.inv_cover  <= FullScale;
      blend_q.src_term   <= {NumChan{HalfScale}};
    end else begin
      right_eff_q <= left_q + wid_a_q;
      blend_q     <= blend_d;
    end
  end

  assign left_o   = left_q;
  assign top_o    = top_q;
  assign bottom_o = bottom_q;
  assign right_o  = right_eff_q;
  assign blend_o  = blend_q;

endmodule

[src/lrab_lane.sv]
// One color channel of the blend: multiply, sum, reciprocal divide, correct.
module lrab_lane
  import lrab_pkg::*;
(
  input  logic        clk_i,
  input  lrab_en_t    en_i,
  input  byte_t       dst_i,
  input  logic [15:0] inv_cover_i,
  input  term_t       src_term_i,
  output byte_t       dst_o,
  output byte_t       mix_o
);

  byte_t            dst2_q, dst3_q, dst4_q;
  term_t            prod2_q, num3_q, num4_q;
  logic [8:0]       quo4_q;
  logic [RecipW-1:0] recip;

  assign recip = RecipW'(num3_q) * RecipW'(RecipMul);

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      dst2_q  <= dst_i;
      prod2_q <= 24'(dst_i) * 24'(inv_cover_i);
    end
    if (en_i.s3) begin
      dst3_q <= dst2_q;
      num3_q <= src_term_i + prod2_q;
    end
    if (en_i.s4) begin
      dst4_q <= dst3_q;
      num4_q <= num3_q;
      quo4_q <= recip[RecipShift +: 9];
    end
  end

  // Estimate is exact or one short; the remainder tells which.
  logic [24:0] back;
  logic [24:0] rem;
  logic [8:0]  quo;

  always_comb begin
    back  = 25'(quo4_q) * 25'(FullScale);
    rem   = 25'(num4_q) - back;
    quo   = quo4_q + 9'(rem >= 25'(FullScale));
    mix_o = (quo > 9'd255) ? 8'd255 : quo[7:0];
  end

  assign dst_o = dst4_q;

endmodule

[src/layer_rect_alpha_blend.sv]
// Top level of the layer rectangle source-over blender.
//
// Takes one destination pixel per clock unless back pressure or a register
// write holds the input off, and returns it source-over blended with the
// solid layer color when it falls inside the layer rectangle, unchanged
// otherwise; m_axis_tuser flags covered pixels. The five register stages
// are input capture, the 1 - a multiply with the rectangle test, the sum
// with the premultiplied source term, a reciprocal multiply for the divide
// by 65025, and the corrected output byte. Each stage stalls on its own,
// so bubbles close up under back pressure and a new pixel enters whenever
// stage one can move. Geometry and color terms are recomputed from the
// registers in derived stages, so the input holds off for the cycle after
// each register write; writes must come while no pixel is in flight.
module layer_rect_alpha_blend
  import lrab_pkg::*;
#(
  parameter int COORD_WIDTH = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pix_x, pix_y, dst_red, dst_green, dst_blue, dst_alpha, zero pad
  input  logic [((2*COORD_WIDTH+32+7)/8)*8-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [31:0]           m_axis_tdata,
  // covered
  output logic                  m_axis_tuser
);

  localparam int EdgeW = COORD_WIDTH + 1;
  localparam int DstLo = 2 * COORD_WIDTH;

  logic [EdgeW-1:0] left, top, bottom, right;
  lrab_blend_t      blend;

  lrab_cfg #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .left_o    (left),
    .top_o     (top),
    .bottom_o  (bottom),
    .right_o   (right),
    .blend_o   (blend)
  );

  // Valid chain and per-stage ready
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic cfg_we_q;
  lrab_en_t en;

  assign rdy5 = !v5_q || m_axis_tready;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign en   = '{s2: rdy2, s3: rdy3, s4: rdy4};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
      v5_q     <= 1'b0;
      cfg_we_q <= 1'b0;
    end else begin
      cfg_we_q <= cfg_we_i;
      if (rdy1) v1_q <= s_axis_tvalid && !cfg_we_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // Stage 1: capture the request
  logic [COORD_WIDTH-1:0] x1_q, y1_q;
  byte_t [NumChan-1:0]    dst1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      x1_q   <= s_axis_tdata[COORD_WIDTH-1:0];
      y1_q   <= s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
      dst1_q <= s_axis_tdata[DstLo +: 32];
    end
  end

  // Stage 2: rectangle test, carried alongside the lanes
  logic in_rect;
  logic inside2_q, inside3_q, inside4_q;

  assign in_rect = (EdgeW'(x1_q) >= left) && (EdgeW'(x1_q) < right) &&
                   (EdgeW'(y1_q) >= top) && (EdgeW'(y1_q) < bottom);

  always_ff @(posedge clk_i) begin
    if (rdy2) inside2_q <= in_rect;
    if (rdy3) inside3_q <= inside2_q;
    if (rdy4) inside4_q <= inside3_q;
  end

  byte_t [NumChan-1:0] dst4, mix4;

  for (genvar c = 0; c < NumChan; c++) begin : g_lane
    lrab_lane u_lane (
      .clk_i      (clk_i),
      .en_i       (en),
      .dst_i      (dst1_q[c]),
      .inv_cover_i(blend.inv_cover),
      .src_term_i (blend.src_term[c]),
      .dst_o      (dst4[c]),
      .mix_o      (mix4[c])
    );
  end

  // Stage 5: output register
  byte_t [NumChan-1:0] out5_q;
  logic                cov5_q;

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      out5_q <= inside4_q ? mix4 : dst4;
      cov5_q <= inside4_q;
    end
  end

  assign s_axis_tready = rdy1 && !cfg_we_q;
  assign m_axis_tvalid = v5_q;
  assign m_axis_tdata  = out5_q;
  assign m_axis_tuser  = cov5_q;

endmodule

[src/lrab_checker.sv]
// Port-level checks for the blender, bound to the top level.
module lrab_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Input only backs up when the whole pipe is full and the output stalls,
  // or for the cycle after a register write
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready && !$past(cfg_we_i) |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with room in the pipe");

  // With the output ready throughout, an accepted request reaches the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
      ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("request lost in the pipe");

  // Valid drops only after a handshake
  a_valid_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid) |-> $past(m_axis_tready))
    else $error("result dropped without handshake");

endmodule

bind layer_rect_alpha_blend lrab_checker u_lrab_checker (.*);

[sim/tb_layer_rect_alpha_blend.sv]
// Self-checking testbench for the layer rectangle source-over blender.
`timescale 1ns / 100ps

module tb_layer_rect_alpha_blend;
  import lrab_pkg::*;

  localparam int unsigned CoordW = 12;
  localparam int unsigned InW = ((2*CoordW+32+7)/8)*8;
  localparam int unsigned Full = 65025;
  localparam int unsigned Half = 32512;
  localparam int unsigned CanvasEdge = 4096;
  localparam int unsigned MaxCoord = 4095;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldCycles = 90;
  localparam int unsigned RandPhases = 11;
  localparam int unsigned PhaseItems = 57;

  // Last member sits in the low bits, so this matches s_axis_tdata bit for bit
  typedef struct packed {
    byte_t             da;
    byte_t             db;
    byte_t             dg;
    byte_t             dr;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } pixel_t;

  // Same layout as {m_axis_tuser, m_axis_tdata}
  typedef struct packed {
    logic                covered;
    byte_t [NumChan-1:0] chan;
  } blend_res_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InW-1:0]      s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [31:0]         m_axis_tdata;
  logic                m_axis_tuser;

  // Local copy of the layer registers, reset values
  logic [12:0] lay_left = '0;
  logic [12:0] lay_top = '0;
  logic [12:0] lay_right = '0;
  logic [12:0] lay_bottom = '0;
  logic [31:0] lay_color = '0;
  logic [7:0]  lay_opacity = 8'd255;
  logic        lay_wipe_en = 1'b0;
  logic [8:0]  lay_wipe_prog = 9'd256;

  pixel_t      pixel_q[$];
  blend_res_t  blend_q[$];
  blend_res_t  oldest;
  int unsigned n_queued = 0;
  int unsigned n_checked = 0;
  int unsigned mismatches = 0;
  int unsigned hold_cnt = 0;
  int unsigned idle_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  string       chan_name[NumChan] = '{"red", "green", "blue", "alpha"};

  always #6 clk_i = ~clk_i;

  layer_rect_alpha_blend #(
    .COORD_WIDTH(CoordW)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  function automatic byte_t mix_chan(int unsigned src, int unsigned cov, int unsigned dst);
    int unsigned q;
    q = (src * cov + dst * (Full - cov) + Half) / Full;
    return (q > 255) ? 8'd255 : byte_t'(q);
  endfunction

  function automatic blend_res_t blend_pixel(pixel_t p);
    int unsigned span;
    int unsigned prog;
    int unsigned right_x;
    int unsigned cov;
    byte_t [NumChan-1:0] dst_b;
    blend_res_t r;
    dst_b = {p.da, p.db, p.dg, p.dr};
    span = (lay_right > lay_left) ? int'(lay_right) - int'(lay_left) : 0;
    if (lay_wipe_en) begin
      prog = (lay_wipe_prog > ProgressOne) ? 256 : int'(lay_wipe_prog);
      span = (span * prog + 128) >> 8;
    end
    right_x = int'(lay_left) + span;
    r.covered = p.x >= lay_left && p.x < right_x && p.y >= lay_top && p.y < lay_bottom;
    r.chan = dst_b;
    if (r.covered) begin
      cov = int'(lay_color[31:24]) * int'(lay_opacity);
      for (int c = 0; c < NumChan; c++) begin
        r.chan[c] = mix_chan((c == ChanAlpha) ? 255 : int'(lay_color[8*c +: 8]), cov,
                             int'(dst_b[c]));
      end
    end
    return r;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    int lo_x, hi_x, lo_y, hi_y, tmp;
    {p.da, p.db, p.dg, p.dr} = $urandom;
    if ($urandom_range(0, 9) < 7) begin
      // aim around the rectangle so both edges get hit
      lo_x = int'(lay_left) - 4;
      hi_x = int'(lay_right) + 4;
      lo_y = int'(lay_top) - 4;
      hi_y = int'(lay_bottom) + 4;
      if (lo_x > hi_x) begin
        tmp = lo_x; lo_x = hi_x; hi_x = tmp;
      end
      if (lo_y > hi_y) begin
        tmp = lo_y; lo_y = hi_y; hi_y = tmp;
      end
      lo_x = (lo_x < 0) ? 0 : ((lo_x > MaxCoord) ? MaxCoord : lo_x);
      hi_x = (hi_x > MaxCoord) ? MaxCoord : hi_x;
      lo_y = (lo_y < 0) ? 0 : ((lo_y > MaxCoord) ? MaxCoord : lo_y);
      hi_y = (hi_y > MaxCoord) ? MaxCoord : hi_y;
      p.x = CoordW'($urandom_range(lo_x, hi_x));
      p.y = CoordW'($urandom_range(lo_y, hi_y));
    end else begin
      p.x = CoordW'($urandom_range(0, MaxCoord));
      p.y = CoordW'($urandom_range(0, MaxCoord));
    end
    return p;
  endfunction

  task automatic add_pix(pixel_t p);
    pixel_q.push_back(p);
    n_queued++;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (n_checked != n_queued);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CfgRectLeft:     lay_left = val[12:0];
      CfgRectTop:      lay_top = val[12:0];
      CfgRectRight:    lay_right = val[12:0];
      CfgRectBottom:   lay_bottom = val[12:0];
      CfgLayerColor:   lay_color = val;
      CfgLayerOpacity: lay_opacity = val[7:0];
      CfgWipeEnable:   lay_wipe_en = val[0];
      CfgWipeProgress: lay_wipe_prog = val[8:0];
      default: ;
    endcase
  endtask

  task automatic set_layer(int unsigned l, int unsigned t, int unsigned r, int unsigned b,
                           logic [31:0] color, logic [7:0] opac, logic wen,
                           logic [8:0] prog);
    wait_drained();
    repeat (6) @(posedge clk_i);
    write_reg(CfgRectLeft, l);
    write_reg(CfgRectTop, t);
    write_reg(CfgRectRight, r);
    write_reg(CfgRectBottom, b);
    write_reg(CfgLayerColor, color);
    write_reg(CfgLayerOpacity, {24'd0, opac});
    write_reg(CfgWipeEnable, {31'd0, wen});
    write_reg(CfgWipeProgress, {23'd0, prog});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    // wait for the derived layer terms to follow the registers
    repeat (3) @(posedge clk_i);
  endtask

  task automatic random_layer();
    int unsigned l, t, r, b, opac, prog;
    logic [31:0] color;
    case ($urandom_range(0, 7))
      0: begin
        l = 0; t = 0; r = CanvasEdge; b = CanvasEdge;
      end
      1: begin
        // zero width
        l = $urandom_range(1, CanvasEdge); r = $urandom_range(0, l);
        t = $urandom_range(0, MaxCoord); b = $urandom_range(t + 1, CanvasEdge);
      end
      2: begin
        // no rows
        t = $urandom_range(1, CanvasEdge); b = $urandom_range(0, t);
        l = $urandom_range(0, MaxCoord); r = $urandom_range(l + 1, CanvasEdge);
      end
      default: begin
        l = $urandom_range(0, MaxCoord); r = l + $urandom_range(1, 700);
        t = $urandom_range(0, MaxCoord); b = t + $urandom_range(1, 700);
        if (r > CanvasEdge) r = CanvasEdge;
        if (b > CanvasEdge) b = CanvasEdge;
      end
    endcase
    color = $urandom;
    case ($urandom_range(0, 4))
      0: color[31:24] = 8'd0;
      1: color[31:24] = 8'd255;
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0: opac = 0;
      1: opac = 255;
      default: opac = $urandom_range(0, 255);
    endcase
    prog = ($urandom_range(0, 4) == 0) ? 256 : $urandom_range(0, 511);
    set_layer(l, t, r, b, color, 8'(opac), 1'($urandom_range(0, 1)), 9'(prog));
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        blend_q.push_back(blend_pixel(pixel_t'(s_axis_tdata)));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pixel_q.size() != 0 && (calm || $urandom_range(0, 99) >= 7)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pixel_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (blend_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got tdata %h tuser %b",
                   $time, m_axis_tdata, m_axis_tuser);
          mismatches++;
        end else begin
          oldest = blend_q.pop_front();
          n_checked++;
          for (int c = 0; c < NumChan; c++) begin
            if (m_axis_tdata[8*c +: 8] !== oldest.chan[c]) begin
              $display("%0t: %s expected %0d, got %0d", $time, chan_name[c],
                       oldest.chan[c], m_axis_tdata[8*c +: 8]);
              mismatches++;
            end
          end
          if (m_axis_tuser !== oldest.covered) begin
            $display("%0t: covered expected %b, got %b", $time, oldest.covered,
                     m_axis_tuser);
            mismatches++;
          end
        end
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        // long hold-off: pipe fills and input must stall
        hold_req = 1'b0;
        hold_cnt = HoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("tb_layer_rect_alpha_blend: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Pixels below are {dst rgba with red low, y, x}
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset registers: empty rectangle, everything passes through
    add_pix({32'h0000_0000, 12'd0, 12'd0});
    add_pix({32'hFFFF_FFFF, 12'd4095, 12'd4095});
    add_pix({32'h8040_C020, 12'd4095, 12'd0});

    // small rectangle, probe every edge from both sides
    set_layer(10, 5, 20, 15, 32'h8040_C0FF, 8'd200, 1'b0, 9'd256);
    add_pix({32'h0000_0000, 12'd5, 12'd10});
    add_pix({32'hFFFF_FFFF, 12'd5, 12'd9});
    add_pix({32'hFFFF_FFFF, 12'd14, 12'd19});
    add_pix({32'h1234_5678, 12'd14, 12'd20});
    add_pix({32'h0000_0000, 12'd4, 12'd10});
    add_pix({32'h0000_0000, 12'd15, 12'd10});

    // whole canvas, opaque layer
    set_layer(0, 0, CanvasEdge, CanvasEdge, 32'hFF12_3456, 8'd255, 1'b0, 9'd256);
    add_pix({32'hFFFF_FFFF, 12'd0, 12'd0});
    add_pix({32'h0000_0000, 12'd4095, 12'd4095});

    // zero opacity, then zero layer alpha
    set_layer(0, 0, CanvasEdge, CanvasEdge, 32'hFFAB_CDEF, 8'd0, 1'b0, 9'd256);
    add_pix({32'h80A0_C0E0, 12'd2048, 12'd2048});
    set_layer(0, 0, CanvasEdge, CanvasEdge, 32'h00FF_FFFF, 8'd255, 1'b0, 9'd256);
    add_pix({32'hFF00_FF00, 12'd0, 12'd4095});

    // inverted width, inverted height
    set_layer(100, 0, 50, CanvasEdge, 32'hFFFF_FFFF, 8'd255, 1'b0, 9'd256);
    add_pix({32'h1020_3040, 12'd10, 12'd75});
    add_pix({32'h1020_3040, 12'd10, 12'd100});
    set_layer(0, 200, CanvasEdge, 100, 32'hFFFF_FFFF, 8'd255, 1'b0, 9'd256);
    add_pix({32'h5060_7080, 12'd150, 12'd10});

    // wipe at half, then past one (clamped), then at zero
    set_layer(0, 0, 100, CanvasEdge, 32'hC080_4020, 8'd128, 1'b1, 9'd128);
    add_pix({32'h0000_0000, 12'd0, 12'd49});
    add_pix({32'h0000_0000, 12'd0, 12'd50});
    set_layer(0, 0, 100, CanvasEdge, 32'hC080_4020, 8'd128, 1'b1, 9'd511);
    add_pix({32'hFFFF_FFFF, 12'd7, 12'd99});
    add_pix({32'hFFFF_FFFF, 12'd7, 12'd100});
    set_layer(0, 0, 100, CanvasEdge, 32'hC080_4020, 8'd128, 1'b1, 9'd0);
    add_pix({32'hFFFF_FFFF, 12'd0, 12'd0});

    for (int ph = 0; ph < RandPhases; ph++) begin
      random_layer();
      calm = (ph == 2);
      for (int i = 0; i < PhaseItems; i++) begin
        add_pix(random_pixel());
      end
      if (ph == 5) begin
        hold_req = 1'b1;
      end
    end

    wait_drained();
    repeat (12) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_layer_rect_alpha_blend: PASS");
    end else begin
      $display("tb_layer_rect_alpha_blend: FAIL");
    end
    $finish;
  end

endmodule

[layer_rect_alpha_blend.f]
src/lrab_pkg.sv
src/lrab_cfg.sv
src/lrab_lane.sv
src/layer_rect_alpha_blend.sv
src/lrab_checker.sv
sim/tb_layer_rect_alpha_blend.sv
